[hdl/lfo_waveform_generator_core_macros.svh]
// Assertion macros shared by the oscillator core.
`ifndef LFO_WAVEFORM_GENERATOR_CORE_MACROS_SVH
`define LFO_WAVEFORM_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LFO_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfo assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define LFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfo assertion failed: next-cycle implication");

`endif

[hdl/lfo_pkg.sv]
// Types and constants of the low-frequency oscillator core.
package lfo_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int UNIT_W     = 17;

  // 1.0 in unsigned Q1.16
  localparam logic [UNIT_W-1:0] UNIT_ONE = 17'd65536;
  // 0.9898 in Q0.32, fraction part of the noise hash constant
  localparam logic [31:0] NOISE_FRAC = 32'd4251158630;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQUENCY    = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_AMPLITUDE    = 3'd2,
    REG_LEVEL_OFFSET = 3'd3,
    REG_PULSE_WIDTH  = 3'd4,
    REG_WAVEFORM     = 3'd5
  } cfg_idx_t;

  // Waveform codes; codes above noise behave as noise
  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_NOISE    = 3'd4
  } wave_t;

  // Current register set
  typedef struct packed {
    logic [23:0]        frequency;
    logic [15:0]        phase_offset;
    logic signed [15:0] amplitude;
    logic signed [15:0] level_offset;
    logic [15:0]        pulse_width;
    logic [2:0]         waveform;
  } cfg_regs_t;

  // Shaped value handed to the scaler
  typedef struct packed {
    logic              is_sine;
    logic              lower_half;
    logic [UNIT_W-1:0] sine_val;
    logic [UNIT_W-1:0] alt_unit;
  } shape_t;

endpackage

[hdl/lfo_if.sv]
// Stream and configuration channel interfaces of the oscillator core.
interface lfo_in_if;
  logic                       valid;
  logic                       ready;
  logic [lfo_pkg::TIME_W-1:0] time_value;
  modport source (output valid, output time_value, input ready);
  modport sink   (input valid, input time_value, output ready);
endinterface

interface lfo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] level;
  logic               saturated;
  modport source (output valid, output level, output saturated, input ready);
  modport sink   (input valid, input level, input saturated, output ready);
endinterface

interface lfo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfo_pkg::CFG_IDX_W-1:0]  index;
  logic [lfo_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/lfo_cfg.sv]
// Configuration register file of the oscillator core.
module lfo_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_valid,
  output logic                           wr_ready,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lfo_pkg::CFG_DATA_W-1:0] wr_data,
  output lfo_pkg::cfg_regs_t             regs
);
  import lfo_pkg::*;

  cfg_regs_t regs_r;

  assign wr_ready = 1'b1;
  assign regs     = regs_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.frequency    <= 24'd65536;
      regs_r.phase_offset <= 16'd0;
      regs_r.amplitude    <= 16'sd4096;
      regs_r.level_offset <= 16'sd0;
      regs_r.pulse_width  <= 16'd32768;
      regs_r.waveform     <= WAVE_SINE;
    end else if (wr_valid) begin
      unique case (wr_index)
        REG_FREQUENCY:    regs_r.frequency    <= wr_data[23:0];
        REG_PHASE_OFFSET: regs_r.phase_offset <= wr_data[15:0];
        REG_AMPLITUDE:    regs_r.amplitude    <= $signed(wr_data[15:0]);
        REG_LEVEL_OFFSET: regs_r.level_offset <= $signed(wr_data[15:0]);
        REG_PULSE_WIDTH:  regs_r.pulse_width  <= wr_data[15:0];
        REG_WAVEFORM:     regs_r.waveform     <= wr_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/lfo_phase.sv]
// Phase stages: time times frequency, then phase offset add.
module lfo_phase (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfo_pkg::cfg_regs_t         cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [lfo_pkg::TIME_W-1:0] time_value,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [31:0]                phase
);
  import lfo_pkg::*;

  logic        v1_r, v2_r;
  logic [31:0] mul_r, phase_r;
  logic [55:0] prod_nxt;
  logic        en1, en2;

  // Per-stage load enables; a bubble is filled even under stall
  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v2_r;
  assign phase    = phase_r;

  assign prod_nxt = 56'(time_value) * 56'(cfg.frequency);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  // Stage 1 keeps product bits that reach the phase; stage 2 adds the offset
  always_ff @(posedge clk) begin
    if (en1) mul_r <= prod_nxt[47:16];
    if (en2) phase_r <= mul_r + 32'(cfg.phase_offset);
  end

endmodule

[hdl/lfo_shape.sv]
// Waveform stages: quarter-wave index and other shapes, then sine table read.
module lfo_shape #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lfo_pkg::cfg_regs_t cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [31:0]        phase,
  output logic               dn_valid,
  input  logic               dn_ready,
  output lfo_pkg::shape_t    shape
);
  import lfo_pkg::*;

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = IDX_W + 15;

  // Signed Q30 product truncated toward zero
  function automatic longint mul_q30(input longint a, input longint b);
    logic        neg;
    logic [63:0] ma, mb, m;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    m   = (ma * mb) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Degree-9 odd polynomial for sin(pi/2 * u), u in Q30, result Q1.16
  function automatic logic [UNIT_W-1:0] sine_entry(input longint u);
    longint      u2, acc;
    logic [63:0] r;
    u2  = mul_q30(u, u);
    acc = 172271;
    acc = mul_q30(acc, u2) - 5026991;
    acc = mul_q30(acc, u2) + 85569306;
    acc = mul_q30(acc, u2) - 693598668;
    acc = mul_q30(acc, u2) + 1686629713;
    acc = mul_q30(acc, u);
    if (acc < 0) acc = 0;
    r = (64'(acc) + 64'd8192) >> 14;
    if (r > 64'(UNIT_ONE)) r = 64'(UNIT_ONE);
    return r[UNIT_W-1:0];
  endfunction

  // Constant quarter-wave table, entries 0 .. depth
  logic [UNIT_W-1:0] rom_tbl [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint U = (longint'(k) << 30) / SINE_TABLE_DEPTH;
    assign rom_tbl[k] = sine_entry(U);
  end

  logic              v3_r, v4_r;
  logic              en3, en4;
  logic [IDX_W-1:0]  idx_r;
  logic              is_sine_r, lower_half_r;
  logic [UNIT_W-1:0] alt_r;
  shape_t            shape_r;

  logic [15:0]       frac, ipart;
  logic [13:0]       q;
  logic [14:0]       pos;
  logic [PROD_W-1:0] idx_prod;
  logic [UNIT_W-1:0] two_f, tri_val, alt_nxt;
  logic [31:0]       noise_h;

  assign en4      = !v4_r || dn_ready;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;
  assign dn_valid = v4_r;
  assign shape    = shape_r;

  assign ipart = phase[31:16];
  assign frac  = phase[15:0];
  assign q     = frac[13:0];

  // Quarter-wave position, mirrored in odd quadrants, rounded to a table index
  assign pos      = frac[14] ? 15'd16384 - 15'(q) : 15'(q);
  assign idx_prod = PROD_W'(pos) * PROD_W'(SINE_TABLE_DEPTH) + PROD_W'(8192);

  // Triangle |2F - 1|, noise hash of the integer part
  assign two_f   = {frac, 1'b0};
  assign tri_val = frac[15] ? two_f - UNIT_ONE : UNIT_ONE - two_f;
  assign noise_h = 32'(ipart) * NOISE_FRAC;

  always_comb begin
    case (cfg.waveform)
      WAVE_TRIANGLE: alt_nxt = tri_val;
      WAVE_SAW:      alt_nxt = {1'b0, frac};
      WAVE_SQUARE:   alt_nxt = (frac < cfg.pulse_width) ? UNIT_ONE : '0;
      default:       alt_nxt = {1'b0, noise_h[31:16]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) v3_r <= up_valid;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 3: shapes and index; stage 4: registered table read
  always_ff @(posedge clk) begin
    if (en3) begin
      idx_r        <= idx_prod[IDX_W+13:14];
      is_sine_r    <= (cfg.waveform == WAVE_SINE);
      lower_half_r <= frac[15];
      alt_r        <= alt_nxt;
    end
    if (en4) begin
      shape_r.sine_val   <= rom_tbl[idx_r];
      shape_r.is_sine    <= is_sine_r;
      shape_r.lower_half <= lower_half_r;
      shape_r.alt_unit   <= alt_r;
    end
  end

endmodule

[hdl/lfo_scale.sv]
// Scale stages: gain multiply, then rounding, level offset and saturation.
module lfo_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  lfo_pkg::cfg_regs_t cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  lfo_pkg::shape_t    shape,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic signed [15:0] level,
  output logic               saturated
);
  import lfo_pkg::*;

  logic               v5_r, v6_r;
  logic               en5, en6;
  logic [17:0]        sine_hi, sine_lo;
  logic [UNIT_W-1:0]  unit;
  logic signed [33:0] prod_nxt, prod_r, biased;
  logic signed [17:0] rnd;
  logic signed [18:0] lvl;
  logic signed [15:0] level_r, level_nxt;
  logic               sat_r, sat_nxt;

  assign en6       = !v6_r || dn_ready;
  assign en5       = !v5_r || en6;
  assign up_ready  = en5;
  assign dn_valid  = v6_r;
  assign level     = level_r;
  assign saturated = sat_r;

  // Unit value: sine folded to (1 +/- s) / 2, else the precomputed shape
  assign sine_hi = (18'(UNIT_ONE) + 18'(shape.sine_val)) >> 1;
  assign sine_lo = (18'(UNIT_ONE) - 18'(shape.sine_val)) >> 1;
  assign unit    = !shape.is_sine   ? shape.alt_unit :
                   shape.lower_half ? sine_lo[UNIT_W-1:0] : sine_hi[UNIT_W-1:0];

  assign prod_nxt = $signed({1'b0, unit}) * $signed(cfg.amplitude);

  // Round half up to Q4.12, add offset, clip
  assign biased = prod_r + 34'sd32768;
  assign rnd    = 18'(biased >>> 16);
  assign lvl    = 19'(rnd) + 19'($signed(cfg.level_offset));

  always_comb begin
    level_nxt = lvl[15:0];
    sat_nxt   = 1'b0;
    if (lvl > 19'sd32767) begin
      level_nxt = 16'sh7fff;
      sat_nxt   = 1'b1;
    end else if (lvl < -19'sd32768) begin
      level_nxt = 16'sh8000;
      sat_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en5) v5_r <= up_valid;
      if (en6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) prod_r <= prod_nxt;
    if (en6) begin
      level_r <= level_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

[hdl/lfo_waveform_generator_core.sv]
// Top level of the low-frequency oscillator core.
//
//   channel   dir   handshake      payload
//   in_if     in    valid/ready    time_value (Q16.16 s)
//   out_if    out   valid/ready    level (Q4.12), saturated
//   cfg_if    in    valid/ready    index, data (register write)
//
// One item per cycle sustained while out_if is ready; one register stage each for
// the frequency multiply, phase add, shape/index, sine table read, gain
// multiply and round/clip.
// Synchronous active-low reset clears all stage valids and loads register
// defaults; cfg_if is always ready. Backpressure walks up the per-stage valids,
// so empty stages keep filling while out_if stalls and nothing is dropped.
`include "lfo_waveform_generator_core_macros.svh"

module lfo_waveform_generator_core #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic  clk,
  input  logic  rst_n,
  lfo_in_if.sink     in_if,
  lfo_out_if.source  out_if,
  lfo_cfg_if.sink    cfg_if
);
  import lfo_pkg::*;

  cfg_regs_t   regs;
  logic        ph_valid, ph_ready;
  logic [31:0] ph_phase;
  logic        sh_valid, sh_ready;
  shape_t      sh_data;

  lfo_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_if.valid),
    .wr_ready (cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .regs     (regs)
  );

  lfo_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (regs),
    .up_valid   (in_if.valid),
    .up_ready   (in_if.ready),
    .time_value (in_if.time_value),
    .dn_valid   (ph_valid),
    .dn_ready   (ph_ready),
    .phase      (ph_phase)
  );

  lfo_shape #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (regs),
    .up_valid (ph_valid),
    .up_ready (ph_ready),
    .phase    (ph_phase),
    .dn_valid (sh_valid),
    .dn_ready (sh_ready),
    .shape    (sh_data)
  );

  lfo_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (regs),
    .up_valid  (sh_valid),
    .up_ready  (sh_ready),
    .shape     (sh_data),
    .dn_valid  (out_if.valid),
    .dn_ready  (out_if.ready),
    .level     (out_if.level),
    .saturated (out_if.saturated)
  );

  // A clipped item sits at one of the two rails
  `LFO_ASSERT_IMPLY(a_sat_rail, clk, rst_n, out_if.valid && out_if.saturated, out_if.level == 16'sh7fff || out_if.level == 16'sh8000)
  // Input stalls only when every stage is full and the output is held
  `LFO_ASSERT_IMPLY(a_stall_source, clk, rst_n, !in_if.ready, out_if.valid && !out_if.ready)
  // A middle stage that cannot drain keeps the output occupied next cycle
  `LFO_ASSERT_NEXT(a_full_hold, clk, rst_n, sh_valid && !sh_ready && !out_if.ready, out_if.valid)

endmodule
